@@ rtl/size_class_block_allocator_assert.svh @@
// ---------------------------------------------------------------------------
// size_class_block_allocator_assert.svh
// Assertion macros for the size-class block allocator. They expand to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scba: same-cycle check failed");
// next-cycle implication
`define SCBA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scba: next-cycle check failed");
`else
`define SCBA_ASSERT_IMP(lbl, ante, cons)
`define SCBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/scba_pkg.sv @@
// ---------------------------------------------------------------------------
// scba_pkg
// Sizes, types, codes and the size-class function shared by the allocator.
// ---------------------------------------------------------------------------
package scba_pkg;

    localparam int PARTITIONS           = 8;
    localparam int SIZE_CLASSES         = 16;
    localparam int BLOCKS_PER_PARTITION = 65536;

    localparam int ID_W      = 16;
    localparam int UNITS_W   = 16;
    localparam int PART_IN_W = 3;
    localparam int COUNT_W   = 17;
    localparam int BUMP_W    = 17;

    // block ids are 16 bits wide, so capacity never exceeds 65536
    localparam int CAPACITY = (BLOCKS_PER_PARTITION < 65536) ? BLOCKS_PER_PARTITION : 65536;

    localparam int PART_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int LOG_W   = $clog2(UNITS_W);
    localparam int CLASS_W = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int LIST_N  = PARTITIONS * SIZE_CLASSES;
    localparam int LIST_AW = (LIST_N > 1) ? $clog2(LIST_N) : 1;
    localparam int LINK_N  = PARTITIONS * CAPACITY;
    localparam int LINK_AW = $clog2(LINK_N);
    localparam int BLK_AW  = $clog2(CAPACITY);

    typedef logic [PART_W-1:0]  part_idx_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [LIST_AW-1:0] list_addr_t;
    typedef logic [LINK_AW-1:0] link_addr_t;
    typedef logic [BLK_AW-1:0]  blk_addr_t;
    typedef logic [ID_W-1:0]    id_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BUMP_W-1:0]  bump_t;
    typedef logic [BUMP_W:0]    bump_sum_t;

    localparam count_t COUNT_MAX = '1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_REUSED  = 2'd0,
        ST_FRESH   = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_FREED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_POP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;        // latch request, read head/count
        logic link_rd;        // read next-link of the list head
        logic finish_lookup;  // commit bump or free, load result
        logic finish_pop;     // commit pop, load result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_pop;   // allocate hits a non-empty list
        logic slot_free;  // output register can take a result
    } stat_t;

    // floor(log2(units)); zero and classes past the top map to class 0
    function automatic class_t size_class(input logic [UNITS_W-1:0] units);
        logic [LOG_W-1:0] lg;
        lg = '0;
        for (int i = 1; i < UNITS_W; i++)
        begin
            if (units[i])
            begin
                lg = LOG_W'(i);
            end
        end
        if (int'(lg) >= SIZE_CLASSES)
        begin
            lg = '0;
        end
        return class_t'(lg);
    endfunction

endpackage

@@ rtl/scba_controller.sv @@
// ---------------------------------------------------------------------------
// scba_controller
// Request sequencer: capture, list lookup, optional link pop, result hand-off.
// ---------------------------------------------------------------------------
module scba_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  scba_pkg::stat_t  stat,
    output scba_pkg::cmd_t   cmd
);

    scba_pkg::state_t state_reg;
    scba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = scba_pkg::S_LOOKUP;
                end
            end
            scba_pkg::S_LOOKUP:
            begin
                if (stat.need_pop)
                begin
                    state_next = scba_pkg::S_POP;
                end
                else if (stat.slot_free)
                begin
                    state_next = scba_pkg::S_IDLE;
                end
            end
            scba_pkg::S_POP:
            begin
                if (stat.slot_free)
                begin
                    state_next = scba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            scba_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            scba_pkg::S_LOOKUP:
            begin
                cmd.link_rd       = stat.need_pop;
                cmd.finish_lookup = !stat.need_pop && stat.slot_free;
            end
            scba_pkg::S_POP:
            begin
                cmd.finish_pop = stat.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/scba_datapath.sv @@
// ---------------------------------------------------------------------------
// scba_datapath
// Request registers, head/count memory with valid bits, next-link memory,
// bump pointers and the result register.
// ---------------------------------------------------------------------------
module scba_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              action,
    input  logic [scba_pkg::PART_IN_W-1:0]    partition,
    input  logic [scba_pkg::UNITS_W-1:0]      size_units,
    input  logic [scba_pkg::ID_W-1:0]         block_id,
    input  logic                              out_ready,
    input  scba_pkg::cmd_t                    cmd,
    output scba_pkg::stat_t                   stat,
    output logic                              out_valid,
    output logic [scba_pkg::ID_W-1:0]         granted_block,
    output logic [1:0]                        status
);

    typedef struct packed {
        scba_pkg::id_t    head;
        scba_pkg::count_t count;
    } hc_t;

    // request registers
    logic                            act_reg;
    scba_pkg::part_idx_t             part_reg;
    logic                            part_ok_reg;
    logic [scba_pkg::UNITS_W-1:0]    units_reg;
    scba_pkg::id_t                   blk_reg;
    scba_pkg::list_addr_t            li_reg;

    // head/count store
    hc_t                             hc_mem [scba_pkg::LIST_N];
    hc_t                             hc_rd_reg;
    logic [scba_pkg::LIST_N-1:0]     list_vld_reg;
    logic                            vld_rd_reg;

    // next-link store
    scba_pkg::id_t                   link_mem [scba_pkg::LINK_N];
    scba_pkg::id_t                   link_rd_reg;

    scba_pkg::bump_t                 bump_reg [scba_pkg::PARTITIONS];

    logic                            out_valid_reg;
    scba_pkg::id_t                   granted_reg;
    scba_pkg::status_t               status_reg;

    scba_pkg::class_t                cls_in;
    scba_pkg::part_idx_t             part_in;
    scba_pkg::list_addr_t            li_in;
    scba_pkg::id_t                   eff_head;
    scba_pkg::count_t                eff_count;
    scba_pkg::bump_t                 start;
    scba_pkg::bump_sum_t             bump_sum;
    logic                            fits;
    logic                            blk_ok;
    logic                            free_ok;
    logic                            bump_take;
    logic                            hc_we;
    hc_t                             hc_wdata;
    scba_pkg::link_addr_t            link_raddr;
    scba_pkg::link_addr_t            link_waddr;
    scba_pkg::count_t                count_inc;
    scba_pkg::id_t                   granted_next;
    scba_pkg::status_t               status_next;
    logic                            slot_free;

    always_comb
    begin
        cls_in  = scba_pkg::size_class(size_units);
        part_in = scba_pkg::part_idx_t'(partition);
        li_in   = scba_pkg::list_addr_t'(int'(part_in) * scba_pkg::SIZE_CLASSES + int'(cls_in));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg     <= action;
            part_reg    <= part_in;
            part_ok_reg <= (int'(partition) < scba_pkg::PARTITIONS);
            units_reg   <= size_units;
            blk_reg     <= block_id;
            li_reg      <= li_in;
        end
    end

    // an entry that was never written reads as an empty list
    always_comb
    begin
        eff_head  = vld_rd_reg ? hc_rd_reg.head  : '0;
        eff_count = vld_rd_reg ? hc_rd_reg.count : '0;
        count_inc = (eff_count == scba_pkg::COUNT_MAX) ? eff_count
                                                       : eff_count + 1'b1;
    end

    always_comb
    begin
        start     = bump_reg[part_reg];
        bump_sum  = {1'b0, start} + scba_pkg::bump_sum_t'(units_reg);
        fits      = (int'(bump_sum) <= scba_pkg::CAPACITY)
                    && (int'(start) < scba_pkg::CAPACITY);
        blk_ok    = (int'(blk_reg) < scba_pkg::CAPACITY);
        free_ok   = (act_reg == scba_pkg::ACT_FREE) && part_ok_reg && blk_ok;
        stat.need_pop = (act_reg == scba_pkg::ACT_ALLOC) && part_ok_reg
                        && (eff_count != '0);
        stat.slot_free = slot_free;
        bump_take = cmd.finish_lookup && (act_reg == scba_pkg::ACT_ALLOC)
                    && part_ok_reg && fits;
        link_raddr = scba_pkg::link_addr_t'(int'(part_reg) * scba_pkg::CAPACITY
                     + int'(scba_pkg::blk_addr_t'(eff_head)));
        link_waddr = scba_pkg::link_addr_t'(int'(part_reg) * scba_pkg::CAPACITY
                     + int'(scba_pkg::blk_addr_t'(blk_reg)));
    end

    always_comb
    begin
        hc_we    = 1'b0;
        hc_wdata = '0;
        if (cmd.finish_lookup && free_ok)
        begin
            hc_we          = 1'b1;
            hc_wdata.head  = blk_reg;
            hc_wdata.count = count_inc;
        end
        else if (cmd.finish_pop)
        begin
            hc_we          = 1'b1;
            hc_wdata.head  = link_rd_reg;
            hc_wdata.count = eff_count - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hc_we)
        begin
            hc_mem[li_reg] <= hc_wdata;
        end
        if (cmd.capture)
        begin
            hc_rd_reg  <= hc_mem[li_in];
            vld_rd_reg <= list_vld_reg[li_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_vld_reg <= '0;
        end
        else if (hc_we)
        begin
            list_vld_reg[li_reg] <= 1'b1;
        end
    end

    // free pushes: link of the freed block points at the old head
    always_ff @(posedge clk)
    begin
        if (cmd.finish_lookup && free_ok)
        begin
            link_mem[link_waddr] <= (eff_count != '0) ? eff_head : '0;
        end
        if (cmd.link_rd)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scba_pkg::PARTITIONS; i++)
            begin
                bump_reg[i] <= '0;
            end
        end
        else if (bump_take)
        begin
            bump_reg[part_reg] <= scba_pkg::bump_t'(bump_sum);
        end
    end

    always_comb
    begin
        granted_next = '0;
        status_next  = scba_pkg::ST_NOSPACE;
        priority if (cmd.finish_pop)
        begin
            granted_next = eff_head;
            status_next  = scba_pkg::ST_REUSED;
        end
        else if (act_reg == scba_pkg::ACT_FREE)
        begin
            status_next = scba_pkg::ST_FREED;
        end
        else if (part_ok_reg && fits)
        begin
            granted_next = scba_pkg::id_t'(start);
            status_next  = scba_pkg::ST_FRESH;
        end
        else
        begin
            status_next = scba_pkg::ST_NOSPACE;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish_lookup || cmd.finish_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_lookup || cmd.finish_pop)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_block = granted_reg;
    assign status        = status_reg;

endmodule

@@ rtl/size_class_block_allocator.sv @@
// Sequence: a free, a bump allocation or a no_space result is registered after the capture and
// the head/count lookup; an allocation popped from a free list adds a next-link memory read.
// Throughput: one request at a time; the next is accepted only once the result is loaded, and
// loading stalls while the output register holds a result that out_ready has not taken.
// Reset: rst_n asynchronous active low; all free lists empty, bump pointers zero.
// ---------------------------------------------------------------------------
// size_class_block_allocator
// Power-of-two size-class block allocator with per-partition LIFO free lists
// and bump allocation when a list is empty.
// ---------------------------------------------------------------------------
`include "size_class_block_allocator_assert.svh"

module size_class_block_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [scba_pkg::PART_IN_W-1:0]    partition,
    input  logic [scba_pkg::UNITS_W-1:0]      size_units,
    input  logic [scba_pkg::ID_W-1:0]         block_id,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [scba_pkg::ID_W-1:0]         granted_block,
    output logic [1:0]                        status
);

    scba_pkg::cmd_t  cmd;
    scba_pkg::stat_t stat;

    scba_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scba_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .partition     (partition),
        .size_units    (size_units),
        .block_id      (block_id),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .granted_block (granted_block),
        .status        (status)
    );

    // one request in flight: busy straight after an input transaction
    `SCBA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // a new result only ever follows a busy cycle
    `SCBA_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready))
    // no_space and freed carry no block id
    `SCBA_ASSERT_IMP(a_nospace_zero, out_valid && (status == scba_pkg::ST_NOSPACE), granted_block == '0)
    `SCBA_ASSERT_IMP(a_freed_zero, out_valid && (status == scba_pkg::ST_FREED), granted_block == '0)

endmodule
